// ===== rtl/rotated_sprite_alpha_compositor_macros.svh =====
// ----------------------------------------------------------------------------
// rotated sprite compositor assertion macros
// concurrent assertion shorthands clocked on clk_i, idle while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ROTATED_SPRITE_ALPHA_COMPOSITOR_MACROS_SVH
`define ROTATED_SPRITE_ALPHA_COMPOSITOR_MACROS_SVH

// same-cycle implication
`define RSAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsac: same-cycle check failed");

// next-cycle implication
`define RSAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsac: next-cycle check failed");

`endif

// ===== rtl/rsac_pkg.sv =====
// ----------------------------------------------------------------------------
// rsac_pkg
// shared types, codes and pixel helpers of the rotated sprite compositor
// ----------------------------------------------------------------------------
`default_nettype none

package rsac_pkg;

  // item kind carried in tuser
  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_COMPOSE = 1'b1
  } mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ROT_COS   = 3'd0,
    CFG_ROT_SIN   = 3'd1,
    CFG_BOX_X_MIN = 3'd2,
    CFG_BOX_X_MAX = 3'd3,
    CFG_BOX_Y_MIN = 3'd4,
    CFG_BOX_Y_MAX = 3'd5
  } cfg_idx_e;

  // fixed point of the rotation terms
  localparam int unsigned Q_FRAC = 14;
  localparam int unsigned Q_HALF = 8192;

  // control traveling with a pixel into the blend unit
  typedef struct packed {
    logic valid;
    logic hit;
  } pix_ctl_t;

  // argb4444 to argb8888, a nibble times 17 is the nibble repeated
  function automatic logic [31:0] expand4444(input logic [15:0] p);
    return {p[15:12], p[15:12], p[11:8], p[11:8], p[7:4], p[7:4], p[3:0], p[3:0]};
  endfunction

  // exact floor(n / 255) for n up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [15:0] s;
    s = n + {8'd0, n[15:8]} + 16'd1;
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rsac_blend.sv =====
// ----------------------------------------------------------------------------
// rsac_blend
// two-stage alpha blend of an expanded sprite texel over a destination pixel,
// the second stage is the output register of the block
// ----------------------------------------------------------------------------
`default_nettype none

module rsac_blend (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  rsac_pkg::pix_ctl_t ctl_i,
  input  logic [15:0]        texel_i,
  input  logic [31:0]        dpix_i,
  output logic               valid_o,
  output logic [31:0]        pixel_o,
  output logic               covered_o
);
  import rsac_pkg::*;

  logic [31:0] sp;
  logic [7:0]  sa, ia;
  logic [15:0] r_d, g_d, b_d;
  logic        a_zero, a_full;

  logic        va_q;
  logic        cov_a_q, full_a_q;
  logic [31:0] sp_a_q, dp_a_q;
  logic [15:0] r_a_q, g_a_q, b_a_q;

  logic        out_v_q;
  logic [31:0] out_pix_q, out_pix_d;
  logic        out_cov_q;

  // expand texel and form weighted channel sums
  always_comb begin
    sp     = expand4444(texel_i);
    sa     = sp[31:24];
    ia     = 8'd255 - sa;
    a_zero = (texel_i[15:12] == 4'h0);
    a_full = (texel_i[15:12] == 4'hF);
    r_d    = 16'(sp[23:16] * sa) + 16'(dpix_i[23:16] * ia);
    g_d    = 16'(sp[15:8] * sa) + 16'(dpix_i[15:8] * ia);
    b_d    = 16'(sp[7:0] * sa) + 16'(dpix_i[7:0] * ia);
  end

  // stage a control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= ctl_i.valid;
    end
  end

  // stage a payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cov_a_q  <= ctl_i.hit && !a_zero;
      full_a_q <= a_full;
      sp_a_q   <= sp;
      dp_a_q   <= dpix_i;
      r_a_q    <= r_d;
      g_a_q    <= g_d;
      b_a_q    <= b_d;
    end
  end

  // divide by 255 and pick the result pixel
  always_comb begin
    if (!cov_a_q) begin
      out_pix_d = dp_a_q;
    end else if (full_a_q) begin
      out_pix_d = sp_a_q;
    end else begin
      out_pix_d = {8'hFF, div255(r_a_q), div255(g_a_q), div255(b_a_q)};
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= va_q;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_pix_q <= out_pix_d;
      out_cov_q <= cov_a_q;
    end
  end

  assign valid_o   = out_v_q;
  assign pixel_o   = out_pix_q;
  assign covered_o = out_cov_q;

endmodule

`default_nettype wire

// ===== rtl/rotated_sprite_alpha_compositor.sv =====
// ----------------------------------------------------------------------------
// rotated_sprite_alpha_compositor
// loads an argb4444 sprite and blends it, inverse-rotated about the image
// centre, over a stream of argb8888 destination pixels
// ----------------------------------------------------------------------------
// a compose item passes stages 1 to 6, blend stage a and the output register
// throughput: one item per cycle unless the result side stalls; a load item writes
// the sprite memory from stage 5, where compose items read it, so item order holds
// back-pressure on the result side stalls the whole pipeline in place
// reset clears valid bits and loads the register reset values; the sprite
// memory is not cleared and must be written before it is used
`default_nettype none

`include "rotated_sprite_alpha_compositor_macros.svh"

module rotated_sprite_alpha_compositor #(
  parameter int unsigned SPRITE_W         = 63,
  parameter int unsigned SPRITE_H         = 240,
  parameter int unsigned IMAGE_W          = 480,
  parameter int unsigned IMAGE_H          = 480,
  parameter int unsigned SPRITE_PIVOT_COL = 32,
  parameter int unsigned SPRITE_PIVOT_ROW = 50
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // texel_index[13:0], texel_value[29:14], dest_x[38:30], dest_y[47:39],
  // dest_pixel[79:48]
  input  logic [79:0]         s_axis_tdata,
  // mode[0]
  input  rsac_pkg::mode_e     s_axis_tuser,
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_pixel[31:0]
  output logic [31:0]         m_axis_tdata,
  // covered[0]
  output logic                m_axis_tuser
);
  import rsac_pkg::*;

  localparam int unsigned DEPTH = SPRITE_W * SPRITE_H;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (SPRITE_W > 1) ? $clog2(SPRITE_W) : 1;
  localparam int unsigned RW    = (SPRITE_H > 1) ? $clog2(SPRITE_H) : 1;
  localparam int unsigned CX    = IMAGE_W / 2;
  localparam int unsigned CY    = IMAGE_H / 2;
  localparam int unsigned CMAX  = (CX > CY) ? CX : CY;
  localparam int unsigned FXW   = (($clog2(CMAX + 1) > 9) ? $clog2(CMAX + 1) : 9) + 1;
  localparam int unsigned PW    = FXW + 16;
  localparam int unsigned SW    = PW + 1;
  localparam int unsigned QW    = SW - Q_FRAC;
  localparam int unsigned SXW   = QW + 1;

  localparam logic signed [FXW-1:0] CX_S    = FXW'(CX);
  localparam logic signed [FXW-1:0] CY_S    = FXW'(CY);
  localparam logic signed [SW-1:0]  HALF_S  = SW'(Q_HALF);
  localparam logic signed [SW-1:0]  RND_S   = SW'((1 << Q_FRAC) - 1);
  localparam logic signed [SXW-1:0] PCOL_S  = SXW'(SPRITE_PIVOT_COL);
  localparam logic signed [SXW-1:0] PROW_S  = SXW'(SPRITE_PIVOT_ROW);
  localparam logic signed [SXW-1:0] SPW_S   = SXW'(SPRITE_W);
  localparam logic signed [SXW-1:0] SPH_S   = SXW'(SPRITE_H);

  // input fields
  logic [13:0] texel_index;
  logic [15:0] texel_value;
  logic [8:0]  dest_x, dest_y;
  logic [31:0] dest_pixel;

  assign texel_index = s_axis_tdata[13:0];
  assign texel_value = s_axis_tdata[29:14];
  assign dest_x      = s_axis_tdata[38:30];
  assign dest_y      = s_axis_tdata[47:39];
  assign dest_pixel  = s_axis_tdata[79:48];

  // configuration registers
  logic signed [15:0] cos_q, sin_q;
  logic [8:0]         bx_min_q, bx_max_q, by_min_q, by_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= 16'sd16384;
      sin_q    <= 16'sd0;
      bx_min_q <= 9'd0;
      bx_max_q <= 9'd479;
      by_min_q <= 9'd0;
      by_max_q <= 9'd479;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROT_COS:   cos_q    <= cfg_data_i;
        CFG_ROT_SIN:   sin_q    <= cfg_data_i;
        CFG_BOX_X_MIN: bx_min_q <= cfg_data_i[8:0];
        CFG_BOX_X_MAX: bx_max_q <= cfg_data_i[8:0];
        CFG_BOX_Y_MIN: by_min_q <= cfg_data_i[8:0];
        CFG_BOX_Y_MAX: by_max_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // pipeline advance, a full output register waiting blocks every stage
  logic adv, out_v;
  assign adv           = !out_v || m_axis_tready;
  assign s_axis_tready = adv;

  logic acc;
  assign acc = s_axis_tvalid && adv;

  // load items travel with the pixels and write when they reach the read stage
  logic          ld_d;
  logic          ld1_q, ld2_q, ld3_q, ld4_q, ld5_q;
  logic [AW-1:0] wa1_q, wa2_q, wa3_q, wa4_q, wa5_q;
  logic [15:0]   wd1_q, wd2_q, wd3_q, wd4_q, wd5_q;

  assign ld_d = acc && (s_axis_tuser == MODE_LOAD) && (32'(texel_index) < DEPTH);

  // sprite memory, written in the same stage where compose items read it
  logic [15:0] sprite_mem [DEPTH];
  logic        wr_en;
  logic [AW-1:0] wr_addr;

  assign wr_en   = adv && ld5_q;
  assign wr_addr = wa5_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sprite_mem[wr_addr] <= wd5_q;
    end
  end

  // stage 1: centre offsets and box test
  logic                  v1_q, in1_q, in1_d;
  logic signed [FXW-1:0] fx1_q, fy1_q, fx1_d, fy1_d;
  logic [31:0]           dp1_q;

  always_comb begin
    fx1_d = $signed({{(FXW-9){1'b0}}, dest_x}) - CX_S;
    fy1_d = $signed({{(FXW-9){1'b0}}, dest_y}) - CY_S;
    in1_d = (dest_x >= bx_min_q) && (dest_x <= bx_max_q) &&
            (dest_y >= by_min_q) && (dest_y <= by_max_q) &&
            (32'(dest_x) < IMAGE_W) && (32'(dest_y) < IMAGE_H);
  end

  // stage 2: rotation products
  logic                 v2_q, in2_q;
  logic signed [PW-1:0] pxc2_q, pys2_q, pyc2_q, pxs2_q;
  logic [31:0]          dp2_q;

  // stage 3: rotated terms plus one half
  logic                 v3_q, in3_q;
  logic signed [SW-1:0] tu3_q, tv3_q, tu3_d, tv3_d;
  logic [31:0]          dp3_q;

  assign tu3_d = SW'(pxc2_q) + SW'(pys2_q) + HALF_S;
  assign tv3_d = SW'(pyc2_q) - SW'(pxs2_q) + HALF_S;

  // stage 4: truncate toward zero, add pivot, sprite range test
  logic                  v4_q, hit4_q, hit4_d;
  logic [CW-1:0]         sx4_q;
  logic [RW-1:0]         sy4_q;
  logic [31:0]           dp4_q;
  logic signed [SW-1:0]  tu_adj, tv_adj;
  logic signed [QW-1:0]  qu, qv;
  logic signed [SXW-1:0] sx4_d, sy4_d;

  always_comb begin
    tu_adj = tu3_q + (tu3_q[SW-1] ? RND_S : '0);
    tv_adj = tv3_q + (tv3_q[SW-1] ? RND_S : '0);
    qu     = QW'(tu_adj >>> Q_FRAC);
    qv     = QW'(tv_adj >>> Q_FRAC);
    sx4_d  = PCOL_S + SXW'(qu);
    sy4_d  = PROW_S + SXW'(qv);
    hit4_d = in3_q && !sx4_d[SXW-1] && (sx4_d < SPW_S) &&
             !sy4_d[SXW-1] && (sy4_d < SPH_S);
  end

  // stage 5: linear sprite address
  logic          v5_q, hit5_q;
  logic [AW-1:0] addr5_q;
  logic [31:0]   dp5_q;

  // stage 6: registered sprite read
  logic          v6_q, hit6_q;
  logic [15:0]   tex6_q;
  logic [31:0]   dp6_q;

  // valid bits of the coordinate pipeline and of the load items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      ld1_q <= 1'b0;
      ld2_q <= 1'b0;
      ld3_q <= 1'b0;
      ld4_q <= 1'b0;
      ld5_q <= 1'b0;
    end else if (adv) begin
      v1_q  <= acc && (s_axis_tuser == MODE_COMPOSE);
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      ld1_q <= ld_d;
      ld2_q <= ld1_q;
      ld3_q <= ld2_q;
      ld4_q <= ld3_q;
      ld5_q <= ld4_q;
    end
  end

  // payload of the coordinate pipeline
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx1_q   <= fx1_d;
      fy1_q   <= fy1_d;
      in1_q   <= in1_d;
      dp1_q   <= dest_pixel;
      wa1_q   <= AW'(texel_index);
      wd1_q   <= texel_value;

      pxc2_q  <= fx1_q * cos_q;
      pys2_q  <= fy1_q * sin_q;
      pyc2_q  <= fy1_q * cos_q;
      pxs2_q  <= fx1_q * sin_q;
      in2_q   <= in1_q;
      dp2_q   <= dp1_q;
      wa2_q   <= wa1_q;
      wd2_q   <= wd1_q;

      tu3_q   <= tu3_d;
      tv3_q   <= tv3_d;
      in3_q   <= in2_q;
      dp3_q   <= dp2_q;
      wa3_q   <= wa2_q;
      wd3_q   <= wd2_q;

      sx4_q   <= CW'(sx4_d);
      sy4_q   <= RW'(sy4_d);
      hit4_q  <= hit4_d;
      dp4_q   <= dp3_q;
      wa4_q   <= wa3_q;
      wd4_q   <= wd3_q;

      addr5_q <= AW'(sy4_q * SPRITE_W) + AW'(sx4_q);
      hit5_q  <= hit4_q;
      dp5_q   <= dp4_q;
      wa5_q   <= wa4_q;
      wd5_q   <= wd4_q;

      tex6_q  <= sprite_mem[addr5_q];
      hit6_q  <= hit5_q;
      dp6_q   <= dp5_q;
    end
  end

  // blend and output register
  pix_ctl_t ctl6;
  assign ctl6.valid = v6_q;
  assign ctl6.hit   = hit6_q;

  rsac_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .ctl_i     (ctl6),
    .texel_i   (tex6_q),
    .dpix_i    (dp6_q),
    .valid_o   (out_v),
    .pixel_o   (m_axis_tdata),
    .covered_o (m_axis_tuser)
  );

  assign m_axis_tvalid = out_v;

  // a covered pixel always leaves with full alpha
  `RSAC_ASSERT_IMP(a_cov_alpha, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:24] == 8'hFF)
  // a sprite hit always maps inside the sprite memory
  `RSAC_ASSERT_NXT(a_addr_rng, adv && v4_q && hit4_q, 32'(addr5_q) < DEPTH)
  // a stall holds the texel read for a hit in place
  `RSAC_ASSERT_NXT(a_tex_hold, !adv && v6_q && hit6_q, $stable(tex6_q))

endmodule

`default_nettype wire
